// ----- design/bipbuf_pkg.sv -----
// ----------------------------------------------------------------------------
// bipbuf_pkg
// Shared types and codes of the bipartite ring buffer allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bipbuf_pkg;

    // Width of every length, offset and space field on the ports
    localparam int FIELD_W = 10;

    // Command codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_ORDER    = 2'd2
    } t_status;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;    // capture the input item
        logic commit;  // update pointers and load the result register
    } t_dp_cmd;

endpackage

`default_nettype wire

// ----- design/bipbuf_ctrl.sv -----
// ----------------------------------------------------------------------------
// bipbuf_ctrl
// Handshake controller: accepts one command, runs it through the datapath
// and holds the result valid until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bipbuf_ctrl
    import bipbuf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_dp_cmd      o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // Result register can take a new value when empty or being drained
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // Hold the command until the result register frees up
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- design/bipbuf_dpath.sv -----
// ----------------------------------------------------------------------------
// bipbuf_dpath
// Pointer datapath: holds start and end pointers, places or releases the
// regions of one command and registers the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module bipbuf_dpath
    import bipbuf_pkg::*;
#(
    parameter int BUFFER_BYTES = 1024
)(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic               i_command,
    input  wire logic [FIELD_W-1:0] i_write_length,
    input  wire logic [FIELD_W-1:0] i_read_length,
    input  wire logic [FIELD_W-1:0] i_write_offset,
    input  wire logic [FIELD_W-1:0] i_read_offset,
    output logic [1:0]              o_status,
    output logic [FIELD_W-1:0]      o_granted_write_offset,
    output logic [FIELD_W-1:0]      o_granted_read_offset,
    output logic [FIELD_W-1:0]      o_tail_space,
    output logic [FIELD_W-1:0]      o_head_space
);

    localparam int PW = $clog2(BUFFER_BYTES);
    // Arithmetic width: holds pointer plus two field lengths without overflow
    localparam int AW = ((PW > FIELD_W) ? PW : FIELD_W) + 2;
    localparam logic [AW-1:0] BUF_SIZE = AW'(BUFFER_BYTES);

    // Captured command
    logic               r_command;
    logic [FIELD_W-1:0] r_wlen, r_rlen, r_woff, r_roff;

    // Pointers
    logic [PW-1:0] r_start, r_end;

    // Result registers
    t_status            r_status;
    logic [FIELD_W-1:0] r_gw, r_gr, r_tail, r_head;

    logic [AW-1:0] s_w, s_r, s_wo, s_ro, s_start, s_end, s_wr, s_adv;
    logic [AW-1:0] cur_tail, cur_head, new_tail, new_head;
    logic [AW-1:0] n_start, n_end, n_gw, n_gr;
    t_status       n_status;
    logic          rel_ok;
    logic [AW-1:0] rel_start;

    // Free tail and head space for a pair of pointers
    function automatic logic [2*AW-1:0] spaces(input logic [AW-1:0] s,
                                               input logic [AW-1:0] e);
        logic [AW-1:0] t;
        logic [AW-1:0] h;
        if (s > e) begin
            t = s - e - AW'(1);
            h = '0;
        end else begin
            t = BUF_SIZE - AW'(1) - e;
            h = (s != '0) ? (s - AW'(1)) : '0;
        end
        return {t, h};
    endfunction

    assign s_w     = AW'(r_wlen);
    assign s_r     = AW'(r_rlen);
    assign s_wo    = AW'(r_woff);
    assign s_ro    = AW'(r_roff);
    assign s_start = AW'(r_start);
    assign s_end   = AW'(r_end);
    assign s_wr    = s_w + s_r;
    assign s_adv   = s_start + s_w;

    assign {cur_tail, cur_head} = spaces(s_start, s_end);

    // Match the released regions against the start pointer
    always_comb begin
        rel_ok    = 1'b1;
        rel_start = s_start;
        priority if (s_start == s_wo) begin
            priority if (s_adv == s_ro) begin
                rel_start = s_adv + s_r;
            end else if (s_ro == '0) begin
                rel_start = s_r;
            end else begin
                rel_ok = 1'b0;
            end
        end else if (s_start == s_ro) begin
            if (s_wo == '0) begin
                rel_start = s_w;
            end else begin
                rel_ok = 1'b0;
            end
        end else if (s_wo == '0) begin
            rel_start = s_wr;
        end else begin
            rel_ok = 1'b0;
        end
        // Drop a release that runs past the buffer end
        if (rel_start >= BUF_SIZE) begin
            rel_ok = 1'b0;
        end
    end

    // Place allocations or apply the release
    always_comb begin
        n_start  = s_start;
        n_end    = s_end;
        n_gw     = '0;
        n_gr     = '0;
        n_status = ST_OK;
        if (r_command == CMD_ALLOC) begin
            priority if (cur_tail >= s_wr) begin
                n_gw  = s_end;
                n_gr  = s_end + s_w;
                n_end = s_end + s_wr;
            end else if (s_w >= s_r && cur_tail >= s_w && cur_head >= s_r) begin
                n_gw  = s_end;
                n_end = s_r;
            end else if (s_w < s_r && cur_tail >= s_r && cur_head >= s_w) begin
                n_gr  = s_end;
                n_end = s_w;
            end else if (cur_head >= s_wr) begin
                n_gr  = s_w;
                n_end = s_wr;
            end else begin
                n_status = ST_NO_SPACE;
            end
        end else begin
            if (rel_ok) begin
                n_start = rel_start;
            end else begin
                n_status = ST_ORDER;
            end
        end
    end

    assign {new_tail, new_head} = spaces(n_start, n_end);

    // Capture the accepted command
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_wlen    <= i_write_length;
            r_rlen    <= i_read_length;
            r_woff    <= i_write_offset;
            r_roff    <= i_read_offset;
        end
    end

    // Advance pointers on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
        end else if (i_cmd.commit) begin
            r_start <= n_start[PW-1:0];
            r_end   <= n_end[PW-1:0];
        end
    end

    // Load result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_gw     <= n_gw[FIELD_W-1:0];
            r_gr     <= n_gr[FIELD_W-1:0];
            r_tail   <= new_tail[FIELD_W-1:0];
            r_head   <= new_head[FIELD_W-1:0];
        end
    end

    assign o_status               = r_status;
    assign o_granted_write_offset = r_gw;
    assign o_granted_read_offset  = r_gr;
    assign o_tail_space           = r_tail;
    assign o_head_space           = r_head;

endmodule

`default_nettype wire

// ----- design/bipartite_ring_buffer_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// bipartite_ring_buffer_allocator_unit
// Allocator for write/read region pairs in a circular buffer.
//
// Input channel (i_valid/o_ready) carries an allocate or a release command
// with region lengths and, for release, the offsets being freed. Output
// channel (o_valid/i_ready) returns one result per command: status, granted
// offsets and the tail and head free space after the command.
// A command accepted in idle is captured, then executed in the execute state;
// its result is registered once the result register is free.
// No new command is accepted while one is in execute, set by the two-state
// controller (capture, then execute) around the single pointer update.
// When the receiver stalls, the result is held in the output register; one
// more command is accepted and then waits in execute until the result is
// taken, and o_ready stays low meanwhile.
// Reset clears start and end pointers (empty buffer) and drops any result.
// ----------------------------------------------------------------------------
`default_nettype none

module bipartite_ring_buffer_allocator_unit
    import bipbuf_pkg::*;
#(
    parameter int BUFFER_BYTES = 1024
)(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_command,
    input  wire logic [FIELD_W-1:0] i_write_length,
    input  wire logic [FIELD_W-1:0] i_read_length,
    input  wire logic [FIELD_W-1:0] i_write_offset,
    input  wire logic [FIELD_W-1:0] i_read_offset,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_status,
    output logic [FIELD_W-1:0]      o_granted_write_offset,
    output logic [FIELD_W-1:0]      o_granted_read_offset,
    output logic [FIELD_W-1:0]      o_tail_space,
    output logic [FIELD_W-1:0]      o_head_space
);

    t_dp_cmd dp_cmd;

    bipbuf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (dp_cmd)
    );

    bipbuf_dpath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dpath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (dp_cmd),
        .i_command              (i_command),
        .i_write_length         (i_write_length),
        .i_read_length          (i_read_length),
        .i_write_offset         (i_write_offset),
        .i_read_offset          (i_read_offset),
        .o_status               (o_status),
        .o_granted_write_offset (o_granted_write_offset),
        .o_granted_read_offset  (o_granted_read_offset),
        .o_tail_space           (o_tail_space),
        .o_head_space           (o_head_space)
    );

endmodule

`default_nettype wire
